@@ hdl/integer_square_root_unit_macros.svh @@
// Assertion macros shared by the square root unit RTL.
`ifndef INTEGER_SQUARE_ROOT_UNIT_MACROS_SVH
`define INTEGER_SQUARE_ROOT_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define ISR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("isr assertion failed");

// Next-cycle implication, disabled while reset is held.
`define ISR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("isr assertion failed");

`endif

@@ hdl/isr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isr_pkg
// Shared widths, seed table and divider status type for the square root unit.
// ----------------------------------------------------------------------------
package isr_pkg;

    localparam int RAD_W  = 32;
    localparam int ROOT_W = 16;
    localparam int POS_W  = 5;
    localparam int CNT_W  = 4;

    typedef struct packed {
        logic              done;
        logic              ovf;
        logic [ROOT_W-1:0] quo;
    } t_div_rsp;

    // Position of the highest set bit, zero for an input of zero or one.
    function automatic logic [POS_W-1:0] top_bit(input logic [RAD_W-1:0] v);
        logic [POS_W-1:0] pos;
        pos = '0;
        for (int i = 0; i < RAD_W; i++) begin
            if (v[i]) begin
                pos = POS_W'(i);
            end
        end
        return pos;
    endfunction

    // First guess, never below the root for any word with that top bit.
    function automatic logic [ROOT_W-1:0] seed(input logic [POS_W-1:0] pos);
        logic [ROOT_W-1:0] g;
        case (pos)
            5'd0:    g = 16'd1;
            5'd1:    g = 16'd2;
            5'd2:    g = 16'd2;
            5'd3:    g = 16'd4;
            5'd4:    g = 16'd5;
            5'd5:    g = 16'd8;
            5'd6:    g = 16'd11;
            5'd7:    g = 16'd16;
            5'd8:    g = 16'd22;
            5'd9:    g = 16'd32;
            5'd10:   g = 16'd45;
            5'd11:   g = 16'd64;
            5'd12:   g = 16'd90;
            5'd13:   g = 16'd128;
            5'd14:   g = 16'd181;
            5'd15:   g = 16'd256;
            5'd16:   g = 16'd362;
            5'd17:   g = 16'd512;
            5'd18:   g = 16'd724;
            5'd19:   g = 16'd1024;
            5'd20:   g = 16'd1448;
            5'd21:   g = 16'd2048;
            5'd22:   g = 16'd2896;
            5'd23:   g = 16'd4096;
            5'd24:   g = 16'd5792;
            5'd25:   g = 16'd8192;
            5'd26:   g = 16'd11585;
            5'd27:   g = 16'd16384;
            5'd28:   g = 16'd23170;
            5'd29:   g = 16'd32768;
            5'd30:   g = 16'd46340;
            5'd31:   g = 16'd65535;
            default: g = 16'd65535;
        endcase
        return g;
    endfunction

endpackage

@@ hdl/isr_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isr_div
// Restoring divider, 32 by 16 bits, one quotient bit per cycle. Flags a
// quotient of 2^16 or more without iterating.
// ----------------------------------------------------------------------------
module isr_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [isr_pkg::RAD_W-1:0]     i_dividend,
    input  logic [isr_pkg::ROOT_W-1:0]    i_divisor,
    output isr_pkg::t_div_rsp             o_rsp
);
    import isr_pkg::*;
    `include "integer_square_root_unit_macros.svh"

    logic              r_run;
    logic              r_done;
    logic              r_ovf;
    logic [CNT_W-1:0]  r_cnt;
    logic [ROOT_W-1:0] r_rem;
    logic [ROOT_W-1:0] r_lo;
    logic [ROOT_W-1:0] r_dvs;

    logic [ROOT_W:0]   trial;
    logic              ge;
    logic [ROOT_W:0]   diff;

    assign trial = {r_rem, r_lo[ROOT_W-1]};
    assign ge    = (trial >= {1'b0, r_dvs});
    assign diff  = trial - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_ovf  <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_dvs <= i_divisor;
                r_rem <= i_dividend[RAD_W-1:ROOT_W];
                r_lo  <= i_dividend[ROOT_W-1:0];
                r_cnt <= '0;
                if (i_dividend[RAD_W-1:ROOT_W] >= i_divisor) begin
                    r_ovf  <= 1'b1;
                    r_done <= 1'b1;
                    r_run  <= 1'b0;
                end else begin
                    r_ovf  <= 1'b0;
                    r_run  <= 1'b1;
                end
            end else if (r_run) begin
                r_rem <= ge ? diff[ROOT_W-1:0] : trial[ROOT_W-1:0];
                r_lo  <= {r_lo[ROOT_W-2:0], ge};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == {CNT_W{1'b1}}) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.ovf  = r_ovf;
    assign o_rsp.quo  = r_lo;

    `ISR_ASSERT_NOW(a_done_idle, i_clk, i_rst_n, r_done, !r_run)
    `ISR_ASSERT_NOW(a_rem_below, i_clk, i_rst_n, r_run, r_rem < r_dvs)
    `ISR_ASSERT_NEXT(a_start_acts, i_clk, i_rst_n, i_start, r_run || r_done)

endmodule

@@ hdl/integer_square_root_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_square_root_unit
// Floor square root of a 32-bit unsigned word by Newton iteration from a
// table seed, each step's quotient taken from a shared iterative divider.
// ----------------------------------------------------------------------------
// A zero input gives its result in the cycle after the transfer.
// Otherwise each Newton step passes S_KICK, which starts the shared
// restoring divider, then S_WAIT until it is done; a step whose quotient
// exceeds 16 bits is flagged by the divider without iterating.
// One item at a time: busy is high from a nonzero transfer to the result strobe.
// Synchronous active-low reset returns to idle; the receiver cannot stall.
module integer_square_root_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [isr_pkg::RAD_W-1:0]     i_radicand,
    output logic                          o_strobe,
    output logic [isr_pkg::ROOT_W-1:0]    o_root
);
    import isr_pkg::*;
    `include "integer_square_root_unit_macros.svh"

    typedef enum logic [1:0] {
        S_IDLE,
        S_KICK,
        S_WAIT
    } t_state;

    t_state            r_state, n_state;
    logic [RAD_W-1:0]  r_rad, n_rad;
    logic [ROOT_W-1:0] r_guess, n_guess;
    logic              r_strobe, n_strobe;
    logic [ROOT_W-1:0] r_root, n_root;

    t_div_rsp          div_rsp;
    logic              div_start;
    logic [ROOT_W:0]   sum;

    assign div_start = (r_state == S_KICK);
    assign sum       = {1'b0, r_guess} + {1'b0, div_rsp.quo};

    isr_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_rad),
        .i_divisor  (r_guess),
        .o_rsp      (div_rsp)
    );

    always_comb begin
        n_state  = r_state;
        n_rad    = r_rad;
        n_guess  = r_guess;
        n_strobe = 1'b0;
        n_root   = r_root;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_rad   = i_radicand;
                    n_guess = seed(top_bit(i_radicand));
                    if (i_radicand == '0) begin
                        n_root   = '0;
                        n_strobe = 1'b1;
                    end else begin
                        n_state = S_KICK;
                    end
                end
            end
            S_KICK: begin
                n_state = S_WAIT;
            end
            S_WAIT: begin
                if (div_rsp.done) begin
                    if (div_rsp.ovf || (div_rsp.quo >= r_guess)) begin
                        n_root   = r_guess;
                        n_strobe = 1'b1;
                        n_state  = S_IDLE;
                    end else begin
                        n_guess = sum[ROOT_W:1];
                        n_state = S_KICK;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_strobe <= 1'b0;
            r_guess  <= '1;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
            r_guess  <= n_guess;
        end
        r_rad  <= n_rad;
        r_root <= n_root;
    end

    assign busy     = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_root   = r_root;

    `ISR_ASSERT_NOW(a_guess_nonzero, i_clk, i_rst_n, busy, r_guess != '0)
    `ISR_ASSERT_NOW(a_strobe_idle, i_clk, i_rst_n, o_strobe, !busy)
    `ISR_ASSERT_NEXT(a_transfer_acts, i_clk, i_rst_n, start && !busy, busy || o_strobe)

endmodule
